FILE: rtl/tqpb_pkg.sv
// shared types and constants of the two-queue priority balancer
package tqpb_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_MOVE
    } state_t;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT     = 2'd1;

    // field widths fixed by the interface
    localparam int unsigned KEY_PORT_W = 8;
    localparam int unsigned COUNT_PORT_W = 5;
    localparam int unsigned LIMIT_W = 5;

    // register reset values
    localparam logic [KEY_PORT_W-1:0] THRESHOLD_RESET = 8'd60;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 5'd2;

endpackage

FILE: rtl/two_queue_two_class_priority_balancer.sv
// two-queue two-class priority balancer: sequencer around a single key store
// results are registered from ST_EXEC for an insert or a remove from empty,
// from ST_POP for a remove, from ST_MOVE for a remove with a rebalancing move
// one transaction at a time: a new command is accepted only in ST_IDLE, reached
// once the result is registered; a move needs two reads of the single read port
// reset: pointers, class counts and result valid cleared, threshold 60,
// balance limit 2; key store contents are not cleared
module two_queue_two_class_priority_balancer #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned KEY_BITS    = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tqpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tqpb_pkg::KEY_PORT_W-1:0]      cfg_data,
    // input transactions
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [tqpb_pkg::KEY_PORT_W-1:0]      s_key_value,
    input  logic                                 s_queue_select,
    // result transactions
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tqpb_pkg::KEY_PORT_W-1:0]      m_removed_key,
    output logic                                 m_removed_valid,
    output logic [1:0]                           m_status,
    output logic                                 m_placed_queue,
    output logic                                 m_moved,
    output logic [tqpb_pkg::KEY_PORT_W-1:0]      m_moved_key,
    output logic [tqpb_pkg::COUNT_PORT_W-1:0]    m_count_first,
    output logic [tqpb_pkg::COUNT_PORT_W-1:0]    m_count_second
);

    import tqpb_pkg::*;

    // stored key width: keys are masked to KEY_BITS, never wider than the port
    localparam int unsigned KEY_W  = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned DIFF_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int unsigned ADDR_W = PTR_W + 2;
    localparam int unsigned RAM_DEPTH = 4 << PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // control state
    state_t state_reg, state_next;
    logic [PTR_W-1:0] rptr_reg [4];
    logic [PTR_W-1:0] rptr_next [4];
    logic [PTR_W-1:0] wptr_reg [4];
    logic [PTR_W-1:0] wptr_next [4];
    logic [CNT_W-1:0] cnt_reg [4];
    logic [CNT_W-1:0] cnt_next [4];
    logic [KEY_PORT_W-1:0] thr_reg;
    logic [LIMIT_W-1:0]    lim_reg;

    // latched transaction and popped key
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic             sel_reg;
    logic [KEY_W-1:0] rkey_reg;

    // result register
    logic                    m_valid_reg;
    logic [KEY_PORT_W-1:0]   res_rkey_reg;
    logic                    res_rvalid_reg;
    logic [1:0]              res_status_reg;
    logic                    res_placed_reg;
    logic                    res_moved_reg;
    logic [KEY_PORT_W-1:0]   res_mkey_reg;
    logic [COUNT_PORT_W-1:0] res_cnt0_reg;
    logic [COUNT_PORT_W-1:0] res_cnt1_reg;

    // result being formed
    logic                  produce;
    logic [KEY_PORT_W-1:0] res_rkey;
    logic                  res_rvalid;
    logic [1:0]            res_status;
    logic                  res_placed;
    logic                  res_moved;
    logic [KEY_PORT_W-1:0] res_mkey;

    // key store access
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [KEY_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [KEY_W-1:0]  ram_rdata;

    // queue lengths and decisions
    logic [CNT_W-1:0] len_first, len_second, len_sel, len_other;
    logic [CNT_W-1:0] len_first_next, len_second_next;
    logic             out_free;
    logic             is_insert;
    logic             sel_empty;
    logic             divert;
    logic             rebalance;
    logic [1:0]       ins_fifo;
    logic             ins_full;
    logic [1:0]       pop_fifo;
    logic [1:0]       other_fifo;
    logic [1:0]       move_fifo;

    tqpb_ram #(
        .DATA_W (KEY_W),
        .DEPTH  (RAM_DEPTH)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshakes
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // queue lengths and the decisions drawn from them
    assign len_first  = cnt_reg[0] + cnt_reg[1];
    assign len_second = cnt_reg[2] + cnt_reg[3];
    assign len_sel    = sel_reg ? len_second : len_first;
    assign len_other  = sel_reg ? len_first : len_second;
    assign is_insert  = (op_reg == OP_INSERT);
    assign sel_empty  = (len_sel == '0);
    assign divert     = (len_first > len_second)
                        && (DIFF_W'(len_first - len_second) > DIFF_W'(lim_reg));
    assign rebalance  = (len_other > len_sel)
                        && (DIFF_W'(len_other - len_sel) > DIFF_W'(lim_reg));
    assign ins_fifo   = {divert, !(KEY_PORT_W'(key_reg) > thr_reg)};
    assign ins_full   = (divert ? len_second : len_first) >= CNT_FULL;
    assign pop_fifo   = {sel_reg, (cnt_reg[{sel_reg, 1'b0}] == '0)};
    assign other_fifo = {!sel_reg, (cnt_reg[{!sel_reg, 1'b0}] == '0)};
    assign move_fifo  = {sel_reg, !(KEY_PORT_W'(ram_rdata) > thr_reg)};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (is_insert || sel_empty) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (rebalance) begin
                    state_next = ST_MOVE;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // key store accesses, fifo updates and result forming
    always_comb begin
        rptr_next  = rptr_reg;
        wptr_next  = wptr_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        produce    = 1'b0;
        res_rkey   = '0;
        res_rvalid = 1'b0;
        res_status = STATUS_OK;
        res_placed = 1'b0;
        res_moved  = 1'b0;
        res_mkey   = '0;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_EXEC: begin
                if (is_insert) begin
                    // insert into the balanced target queue
                    res_placed = divert;
                    if (out_free) begin
                        produce = 1'b1;
                        if (ins_full) begin
                            res_status = STATUS_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = {ins_fifo, wptr_reg[ins_fifo]};
                            ram_wdata = key_reg;
                            wptr_next[ins_fifo] = (wptr_reg[ins_fifo] == PTR_LAST)
                                                  ? '0 : wptr_reg[ins_fifo] + PTR_W'(1);
                            cnt_next[ins_fifo] = cnt_reg[ins_fifo] + CNT_W'(1);
                        end
                    end
                end else if (sel_empty) begin
                    // remove from an empty queue
                    res_status = STATUS_EMPTY;
                    produce    = out_free;
                end else begin
                    // read the head of the selected queue
                    ram_re    = 1'b1;
                    ram_raddr = {pop_fifo, rptr_reg[pop_fifo]};
                    rptr_next[pop_fifo] = (rptr_reg[pop_fifo] == PTR_LAST)
                                          ? '0 : rptr_reg[pop_fifo] + PTR_W'(1);
                    cnt_next[pop_fifo] = cnt_reg[pop_fifo] - CNT_W'(1);
                end
            end
            ST_POP: begin
                if (rebalance) begin
                    // read the head of the longer queue for the move
                    ram_re    = 1'b1;
                    ram_raddr = {other_fifo, rptr_reg[other_fifo]};
                    rptr_next[other_fifo] = (rptr_reg[other_fifo] == PTR_LAST)
                                            ? '0 : rptr_reg[other_fifo] + PTR_W'(1);
                    cnt_next[other_fifo] = cnt_reg[other_fifo] - CNT_W'(1);
                end else begin
                    res_rkey   = KEY_PORT_W'(ram_rdata);
                    res_rvalid = 1'b1;
                    produce    = out_free;
                end
            end
            ST_MOVE: begin
                // place the moved key by class into the selected queue
                res_rkey   = KEY_PORT_W'(rkey_reg);
                res_rvalid = 1'b1;
                res_moved  = 1'b1;
                res_mkey   = KEY_PORT_W'(ram_rdata);
                if (out_free) begin
                    produce   = 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = {move_fifo, wptr_reg[move_fifo]};
                    ram_wdata = ram_rdata;
                    wptr_next[move_fifo] = (wptr_reg[move_fifo] == PTR_LAST)
                                           ? '0 : wptr_reg[move_fifo] + PTR_W'(1);
                    cnt_next[move_fifo] = cnt_reg[move_fifo] + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // queue lengths after this step
    assign len_first_next  = cnt_next[0] + cnt_next[1];
    assign len_second_next = cnt_next[2] + cnt_next[3];

    // sequencer, pointers and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 4; i++) begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            cnt_reg   <= cnt_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
            lim_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data;
                CFG_LIMIT:     lim_reg <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // latch the accepted transaction and the popped key
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            key_reg <= KEY_W'(s_key_value);
            sel_reg <= s_queue_select;
        end
        if (state_reg == ST_POP) begin
            rkey_reg <= ram_rdata;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (produce) begin
            res_rkey_reg   <= res_rkey;
            res_rvalid_reg <= res_rvalid;
            res_status_reg <= res_status;
            res_placed_reg <= res_placed;
            res_moved_reg  <= res_moved;
            res_mkey_reg   <= res_mkey;
            res_cnt0_reg   <= COUNT_PORT_W'(len_first_next);
            res_cnt1_reg   <= COUNT_PORT_W'(len_second_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_key   = res_rkey_reg;
    assign m_removed_valid = res_rvalid_reg;
    assign m_status        = res_status_reg;
    assign m_placed_queue  = res_placed_reg;
    assign m_moved         = res_moved_reg;
    assign m_moved_key     = res_mkey_reg;
    assign m_count_first   = res_cnt0_reg;
    assign m_count_second  = res_cnt1_reg;

endmodule

FILE: rtl/tqpb_ram.sv
// generic simple dual-port ram with registered read
module tqpb_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sim/balancer_checker.sv
// result checker for the two-queue priority balancer: predicts every result and compares
module balancer_checker #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [tqpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tqpb_pkg::KEY_PORT_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [tqpb_pkg::KEY_PORT_W-1:0]      s_key_value,
    input  logic                                 s_queue_select,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [tqpb_pkg::KEY_PORT_W-1:0]      m_removed_key,
    input  logic                                 m_removed_valid,
    input  logic [1:0]                           m_status,
    input  logic                                 m_placed_queue,
    input  logic                                 m_moved,
    input  logic [tqpb_pkg::KEY_PORT_W-1:0]      m_moved_key,
    input  logic [tqpb_pkg::COUNT_PORT_W-1:0]    m_count_first,
    input  logic [tqpb_pkg::COUNT_PORT_W-1:0]    m_count_second,
    output int                                   outstanding,
    output int                                   mismatches,
    output int                                   results_seen,
    output int                                   moves_seen,
    output int                                   drops_seen,
    output int                                   empties_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tqpb_pkg::*;

    // one expected result transaction
    typedef struct packed {
        logic [KEY_PORT_W-1:0]   removed_key;
        logic                    removed_valid;
        logic [1:0]              status;
        logic                    placed_queue;
        logic                    moved;
        logic [KEY_PORT_W-1:0]   moved_key;
        logic [COUNT_PORT_W-1:0] count_first;
        logic [COUNT_PORT_W-1:0] count_second;
    } outcome_t;

    // shadow of the balancer: four class fifos, index {queue, class}, class 0 high
    logic [KEY_PORT_W-1:0] key_slots [4][QUEUE_DEPTH];
    int                    head_ptr [4];
    int                    tail_ptr [4];
    int                    class_fill [4];
    logic [KEY_PORT_W-1:0] threshold;
    int                    balance_limit;

    outcome_t pending_outcomes [$];

    int fail_tally   = 0;
    int result_tally = 0;
    int move_tally   = 0;
    int drop_tally   = 0;
    int empty_tally  = 0;

    assign mismatches   = fail_tally;
    assign results_seen = result_tally;
    assign moves_seen   = move_tally;
    assign drops_seen   = drop_tally;
    assign empties_seen = empty_tally;

    function automatic int queue_len(input logic q);
        return class_fill[{q, 1'b0}] + class_fill[{q, 1'b1}];
    endfunction

    // returns 0 when the queue is already full
    function automatic bit enqueue_key(input logic q, input logic [KEY_PORT_W-1:0] key);
        logic [1:0] fifo;
        if (queue_len(q) >= QUEUE_DEPTH) begin
            return 1'b0;
        end
        fifo = {q, (key > threshold) ? 1'b0 : 1'b1};
        key_slots[fifo][tail_ptr[fifo]] = key;
        tail_ptr[fifo] = (tail_ptr[fifo] + 1) % QUEUE_DEPTH;
        class_fill[fifo]++;
        return 1'b1;
    endfunction

    // high class first; only called on a non-empty queue
    function automatic logic [KEY_PORT_W-1:0] dequeue_key(input logic q);
        logic [1:0]            fifo;
        logic [KEY_PORT_W-1:0] key;
        fifo = {q, 1'b0};
        if (class_fill[fifo] == 0) begin
            fifo = {q, 1'b1};
        end
        key = key_slots[fifo][head_ptr[fifo]];
        head_ptr[fifo] = (head_ptr[fifo] + 1) % QUEUE_DEPTH;
        class_fill[fifo]--;
        return key;
    endfunction

    // apply one command to the shadow state and return the result it should give
    function automatic outcome_t predict_outcome(input logic op,
                                                 input logic [KEY_PORT_W-1:0] key,
                                                 input logic sel);
        outcome_t              res;
        int                    len_a;
        int                    len_b;
        logic [KEY_PORT_W-1:0] shifted;
        res = '0;
        if (op == OP_INSERT) begin
            len_a = queue_len(1'b0);
            len_b = queue_len(1'b1);
            res.placed_queue = (len_a > len_b) && (len_a - len_b > balance_limit);
            if (!enqueue_key(res.placed_queue, key)) begin
                res.status = STATUS_FULL;
            end
        end else if (queue_len(sel) == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.removed_key   = dequeue_key(sel);
            res.removed_valid = 1'b1;
            len_a = queue_len(sel);
            len_b = queue_len(!sel);
            // other queue too long: its head moves into the one just served
            if ((len_b > len_a) && (len_b - len_a > balance_limit)) begin
                shifted = dequeue_key(!sel);
                if (enqueue_key(sel, shifted)) begin
                    res.moved     = 1'b1;
                    res.moved_key = shifted;
                end
            end
        end
        res.count_first  = COUNT_PORT_W'(queue_len(1'b0));
        res.count_second = COUNT_PORT_W'(queue_len(1'b1));
        return res;
    endfunction

    task automatic report(input string field, input int got, input int want);
        $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
                 $realtime, result_tally, field, got, want);
        fail_tally++;
    endtask

    // follow configuration, input and result transactions
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            for (int f = 0; f < 4; f++) begin
                head_ptr[f]   = 0;
                tail_ptr[f]   = 0;
                class_fill[f] = 0;
            end
            threshold     = THRESHOLD_RESET;
            balance_limit = int'(LIMIT_RESET);
            pending_outcomes.delete();
            outstanding <= 0;
        end else begin
            // register writes, unknown indexes are ignored
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_THRESHOLD) begin
                    threshold = cfg_data;
                end else if (cfg_index == CFG_LIMIT) begin
                    balance_limit = int'(cfg_data[LIMIT_W-1:0]);
                end
            end

            // predict on every accepted command
            if (s_valid && s_ready) begin
                want = predict_outcome(s_operation, s_key_value, s_queue_select);
                pending_outcomes.push_back(want);
                if (want.moved) begin
                    move_tally++;
                end
                if (want.status == STATUS_FULL) begin
                    drop_tally++;
                end
                if (want.status == STATUS_EMPTY) begin
                    empty_tally++;
                end
            end

            // compare every accepted result with the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    report("result with nothing pending", 1, 0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_removed_key !== want.removed_key) begin
                        report("removed_key", int'(m_removed_key),
                               int'(want.removed_key));
                    end
                    if (m_removed_valid !== want.removed_valid) begin
                        report("removed_valid", int'(m_removed_valid),
                               int'(want.removed_valid));
                    end
                    if (m_status !== want.status) begin
                        report("status", int'(m_status), int'(want.status));
                    end
                    if (m_placed_queue !== want.placed_queue) begin
                        report("placed_queue", int'(m_placed_queue),
                               int'(want.placed_queue));
                    end
                    if (m_moved !== want.moved) begin
                        report("moved", int'(m_moved), int'(want.moved));
                    end
                    if (m_moved_key !== want.moved_key) begin
                        report("moved_key", int'(m_moved_key), int'(want.moved_key));
                    end
                    if (m_count_first !== want.count_first) begin
                        report("count_first", int'(m_count_first),
                               int'(want.count_first));
                    end
                    if (m_count_second !== want.count_second) begin
                        report("count_second", int'(m_count_second),
                               int'(want.count_second));
                    end
                end
                result_tally++;
            end

            outstanding <= pending_outcomes.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// top of the balancer testbench: clock, reset, stimulus, watchdog and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tqpb_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned KEY_BITS    = 8;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 100;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          TAIL_CYCLES = 12;

    // indexes that name no register
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [KEY_PORT_W-1:0]    cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_operation;
    logic [KEY_PORT_W-1:0]    s_key_value;
    logic                     s_queue_select;
    logic                     m_valid;
    logic                     m_ready;
    logic [KEY_PORT_W-1:0]    m_removed_key;
    logic                     m_removed_valid;
    logic [1:0]               m_status;
    logic                     m_placed_queue;
    logic                     m_moved;
    logic [KEY_PORT_W-1:0]    m_moved_key;
    logic [COUNT_PORT_W-1:0]  m_count_first;
    logic [COUNT_PORT_W-1:0]  m_count_second;

    int outstanding;
    int mismatches;
    int results_seen;
    int moves_seen;
    int drops_seen;
    int empties_seen;

    int items_sent          = 0;
    int cfg_writes          = 0;
    int sender_eager_left   = 0;
    int receiver_eager_left = 0;

    two_queue_two_class_priority_balancer #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_key_value    (s_key_value),
        .s_queue_select (s_queue_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_removed_key  (m_removed_key),
        .m_removed_valid(m_removed_valid),
        .m_status       (m_status),
        .m_placed_queue (m_placed_queue),
        .m_moved        (m_moved),
        .m_moved_key    (m_moved_key),
        .m_count_first  (m_count_first),
        .m_count_second (m_count_second)
    );

    balancer_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_key_value    (s_key_value),
        .s_queue_select (s_queue_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_removed_key  (m_removed_key),
        .m_removed_valid(m_removed_valid),
        .m_status       (m_status),
        .m_placed_queue (m_placed_queue),
        .m_moved        (m_moved),
        .m_moved_key    (m_moved_key),
        .m_count_first  (m_count_first),
        .m_count_second (m_count_second),
        .outstanding    (outstanding),
        .mismatches     (mismatches),
        .results_seen   (results_seen),
        .moves_seen     (moves_seen),
        .drops_seen     (drops_seen),
        .empties_seen   (empties_seen)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // one command transaction, preceded by a random gap unless in an eager stretch
    task automatic send_item(input logic op, input logic [KEY_PORT_W-1:0] key,
                             input logic sel);
        int unsigned gap;
        if (sender_eager_left > 0) begin
            gap = 0;
            sender_eager_left--;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0) begin
                sender_eager_left = $urandom_range(10, 40);
            end
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_key_value    <= key;
        s_queue_select <= sel;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // register write; cfg_valid stays high so writes can follow back to back
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [KEY_PORT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_writes++;
    endtask

    // stimulus
    initial begin
        logic [KEY_PORT_W-1:0] thr;
        logic [KEY_PORT_W-1:0] lim;
        logic [KEY_PORT_W-1:0] key;
        logic                  op;
        int                    insert_pct;
        int                    pause_at;

        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_THRESHOLD;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_operation    <= OP_INSERT;
        s_key_value    <= '0;
        s_queue_select <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: empty removes, class order, diverting, a move
        send_item(OP_REMOVE, 8'h00, 1'b0);
        send_item(OP_REMOVE, 8'hFF, 1'b1);
        send_item(OP_INSERT, 8'h00, 1'b0);
        send_item(OP_INSERT, 8'hFF, 1'b1);
        send_item(OP_INSERT, 8'd60, 1'b0);
        send_item(OP_INSERT, 8'd61, 1'b0);
        send_item(OP_INSERT, 8'd200, 1'b1);
        send_item(OP_REMOVE, 8'h00, 1'b1);
        send_item(OP_REMOVE, 8'h00, 1'b0);
        send_item(OP_REMOVE, 8'h00, 1'b1);
        send_item(OP_INSERT, 8'd128, 1'b1);
        send_item(OP_REMOVE, 8'hFF, 1'b1);

        // directed, limit 16 and threshold 0: fill the first queue and overflow it
        drain_results();
        cfg_write(CFG_LIMIT, 8'd16);
        cfg_write(CFG_THRESHOLD, 8'd0);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 14; i++) begin
            if (i == 0) begin
                key = 8'h00;
            end else if (i == 1) begin
                key = 8'hFF;
            end else begin
                key = KEY_PORT_W'($urandom);
            end
            send_item(OP_INSERT, key, 1'($urandom_range(0, 1)));
        end

        // random phases, each under its own settings, queues carried over
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    thr = KEY_PORT_W'($urandom);  lim = 8'h1F;  insert_pct = 70;
                end
                1: begin
                    thr = 8'hFF;     lim = 8'h00;  insert_pct = 50;
                end
                2: begin
                    thr = 8'h00;     lim = 8'hE1;  insert_pct = 45;
                end
                3: begin
                    thr = KEY_PORT_W'($urandom);  lim = 8'd16;  insert_pct = 60;
                end
                4: begin
                    thr = THRESHOLD_RESET;  lim = KEY_PORT_W'(LIMIT_RESET);
                    insert_pct = 55;
                end
                5: begin
                    thr = KEY_PORT_W'($urandom);
                    lim = KEY_PORT_W'($urandom_range(0, 16));
                    insert_pct = 65;
                end
                6: begin
                    thr = KEY_PORT_W'($urandom);  lim = KEY_PORT_W'($urandom);
                    insert_pct = 30;
                end
                default: begin
                    thr = 8'h80;     lim = 8'd5;   insert_pct = 50;
                end
            endcase
            cfg_write(CFG_THRESHOLD, thr);
            cfg_write(CFG_LIMIT, lim);
            if (p == 0) begin
                cfg_write(CFG_SPARE_LO, KEY_PORT_W'($urandom));
            end
            if (p == 4) begin
                cfg_write(CFG_SPARE_HI, KEY_PORT_W'($urandom));
            end
            cfg_valid <= 1'b0;

            // one phase stops halfway until the block has answered everything
            pause_at = (p == 2) ? PHASE_ITEMS / 2 : PHASE_ITEMS;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at) begin
                    drain_results();
                end
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                case ($urandom_range(0, 7))
                    0:       key = 8'h00;
                    1:       key = 8'hFF;
                    2:       key = thr;
                    3:       key = thr + 8'd1;
                    default: key = KEY_PORT_W'($urandom);
                endcase
                send_item(op, key, 1'($urandom_range(0, 1)));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d commands, %0d results, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("with %0d rebalancing moves, %0d dropped inserts, %0d removes on empty",
                 moves_seen, drops_seen, empties_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random stalls with eager stretches
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (receiver_eager_left > 0) begin
                stall = 0;
                receiver_eager_left--;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 15) == 0) begin
                    receiver_eager_left = $urandom_range(10, 40);
                end
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // watchdog: ends the run when no transaction happens for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule

FILE: two_queue_two_class_priority_balancer.f
rtl/tqpb_pkg.sv
rtl/tqpb_ram.sv
rtl/two_queue_two_class_priority_balancer.sv
sim/balancer_checker.sv
sim/testbench.sv
